FILE: design/wrpt_pkg.sv
// ----------------------------------------------------------------------------
// wrpt_pkg: shared types for the wall reflection path test
// Result payload type, point register indexes and the bound on coordinate width.
// ----------------------------------------------------------------------------
package wrpt_pkg;
  localparam int TAG_BITS = 8;
  localparam int MAX_COORD_BITS = 24;

  // Point register indexes on the config port
  localparam logic [1:0] REG_SOURCE_X = 2'd0;
  localparam logic [1:0] REG_SOURCE_Y = 2'd1;
  localparam logic [1:0] REG_TARGET_X = 2'd2;
  localparam logic [1:0] REG_TARGET_Y = 2'd3;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag_out;
    logic                crossed;
    logic                reflects;
  } result_t;
endpackage

FILE: design/wrpt_if.sv
// ----------------------------------------------------------------------------
// Stream interfaces for the wall reflection path test
// Wall beats in, result beats out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface wrpt_wall_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic [7:0]                   wall_tag;
  logic signed [COORD_BITS-1:0] wall_x1;
  logic signed [COORD_BITS-1:0] wall_y1;
  logic signed [COORD_BITS-1:0] wall_x2;
  logic signed [COORD_BITS-1:0] wall_y2;
  modport source (output valid, wall_tag, wall_x1, wall_y1, wall_x2, wall_y2, input ready);
  modport sink (input valid, wall_tag, wall_x1, wall_y1, wall_x2, wall_y2, output ready);
endinterface

interface wrpt_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] tag_out;
  logic       crossed;
  logic       reflects;
  modport source (output valid, tag_out, crossed, reflects, input ready);
  modport sink (input valid, tag_out, crossed, reflects, output ready);
endinterface

FILE: design/wall_reflection_path_test_unit.sv
// ----------------------------------------------------------------------------
// wall_reflection_path_test_unit
// Wall beats in on wall_in, one result beat per wall out on res_out.
// Source/target points are written through cfg_we/cfg_index/cfg_data
// (index 0 source_x, 1 source_y, 2 target_x, 3 target_y); the user must
// write them only while idle, the block does not enforce it. One wall per
// cycle while the receiver keeps ready, in seven register stages:
// differences, single products, cross/dot sums, sign tests, half-width
// partial products of the crossing ratio, their assembly, and the final
// sum and sign compare. Each stage is at most one narrow multiply deep.
// Reset (rst, synchronous) clears the valid bits and the point registers.
// On a receiver stall a full stage holds while the next one holds, empty
// stages fill, and stage 0 takes a beat once it is free, so nothing is lost.
// ----------------------------------------------------------------------------
module wall_reflection_path_test_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [COORD_BITS-1:0]           cfg_data,
  wrpt_wall_if.sink                       wall_in,
  wrpt_res_if.source                      res_out
);
  import wrpt_pkg::*;

  localparam int D = COORD_BITS + 1;   // differences
  localparam int P = 2 * D + 1;        // cross / dot products
  localparam int L = 2 * D + 1;        // squared length
  localparam int W = P + L + 2;        // crossing ratio terms

  // ratio operands, split in halves so each partial product stays narrow
  localparam int Q = P + 2;
  localparam int K = (Q + 1) / 2;
  localparam int H = Q - K;

  localparam int NST = 7;
  logic [NST-1:0] vld;
  logic [NST-1:0] adv;

  // Per-stage flow: each stage moves when it is empty or the next one moves.
  always_comb begin
    adv[NST-1] = !vld[NST-1] || res_out.ready;
    for (int i = NST - 2; i >= 0; i--) adv[i] = !vld[i] || adv[i+1];
  end
  assign wall_in.ready = adv[0];

  logic signed [COORD_BITS-1:0] sx, sy, tx, ty;
  always_ff @(posedge clk) begin
    if (rst) begin
      sx <= '0; sy <= '0; tx <= '0; ty <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_X: sx <= cfg_data;
        REG_SOURCE_Y: sy <= cfg_data;
        REG_TARGET_X: tx <= cfg_data;
        REG_TARGET_Y: ty <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else begin
      if (adv[0]) vld[0] <= wall_in.valid;
      for (int i = 1; i < NST; i++) if (adv[i]) vld[i] <= vld[i-1];
    end
  end

  // stage 0: differences
  logic [7:0] tg0;
  logic signed [D-1:0] dx0, dy0, ax0, ay0, bx0, by0, cx0, cy0, ex0, ey0, fx0, fy0;
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      tg0 <= wall_in.wall_tag;
      dx0 <= D'(wall_in.wall_x2) - D'(wall_in.wall_x1);
      dy0 <= D'(wall_in.wall_y2) - D'(wall_in.wall_y1);
      ax0 <= D'(tx) - D'(sx);               // S->T
      ay0 <= D'(ty) - D'(sy);
      bx0 <= D'(wall_in.wall_x1) - D'(sx);  // S->P1
      by0 <= D'(wall_in.wall_y1) - D'(sy);
      cx0 <= D'(wall_in.wall_x2) - D'(sx);  // S->P2
      cy0 <= D'(wall_in.wall_y2) - D'(sy);
      ex0 <= D'(sx) - D'(wall_in.wall_x1);  // P1->S
      ey0 <= D'(sy) - D'(wall_in.wall_y1);
      fx0 <= D'(tx) - D'(wall_in.wall_x1);  // P1->T
      fy0 <= D'(ty) - D'(wall_in.wall_y1);
    end
  end

  // stage 1: single products (one multiply per term, pairs combined next)
  logic [7:0] tg1;
  logic signed [P-1:0] m [14];
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      tg1 <= tg0;
      m[0]  <= P'(ax0 * by0);  m[1]  <= P'(ay0 * bx0);
      m[2]  <= P'(ax0 * cy0);  m[3]  <= P'(ay0 * cx0);
      m[4]  <= P'(dx0 * ey0);  m[5]  <= P'(dy0 * ex0);
      m[6]  <= P'(dx0 * fy0);  m[7]  <= P'(dy0 * fx0);
      m[8]  <= P'(dx0 * ex0);  m[9]  <= P'(dy0 * ey0);
      m[10] <= P'(dx0 * fx0);  m[11] <= P'(dy0 * fy0);
      m[12] <= P'(dx0 * dx0);  m[13] <= P'(dy0 * dy0);
    end
  end

  // stage 2: cross products, dots, length
  logic [7:0] tg2;
  logic signed [P:0] o1, o2, hs2, ht2, ps2, pt2;
  logic signed [L:0] len2;
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      tg2  <= tg1;
      o1   <= (P+1)'(m[0]) - (P+1)'(m[1]);
      o2   <= (P+1)'(m[2]) - (P+1)'(m[3]);
      hs2  <= (P+1)'(m[4]) - (P+1)'(m[5]);
      ht2  <= (P+1)'(m[6]) - (P+1)'(m[7]);
      ps2  <= (P+1)'(m[8]) + (P+1)'(m[9]);
      pt2  <= (P+1)'(m[10]) + (P+1)'(m[11]);
      len2 <= (L+1)'(m[12]) + (L+1)'(m[13]);
    end
  end

  // stage 3: crossing flag, reflection guards, normalize hs>0
  logic [7:0] tg3;
  logic cr3, ok3;
  logic signed [P:0] hs3, ht3, ps3, pt3;
  logic signed [L:0] ln3;
  logic signed [P+1:0] hsum3;
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      tg3 <= tg2;
      cr3 <= (o1 != 0) && (o2 != 0) && (o1[P] != o2[P]) &&
             (hs2 != 0) && (ht2 != 0) && (hs2[P] != ht2[P]);
      ok3 <= (len2 != 0) && (hs2 != 0) && (ht2 != 0) && (hs2[P] == ht2[P]);
      hs3 <= hs2[P] ? -hs2 : hs2;
      ht3 <= hs2[P] ? -ht2 : ht2;
      ps3 <= ps2;  pt3 <= pt2;  ln3 <= len2;
      hsum3 <= (P+2)'(hs2[P] ? -hs2 : hs2) + (P+2)'(hs2[P] ? -ht2 : ht2);
    end
  end

  // ratio products: ps*ht, pt*hs, len2*(hs+ht)
  logic signed [Q-1:0] opa [3];
  logic signed [Q-1:0] opb [3];
  always_comb begin
    opa[0] = Q'(ps3);  opb[0] = Q'(ht3);
    opa[1] = Q'(pt3);  opb[1] = Q'(hs3);
    opa[2] = Q'(ln3);  opb[2] = hsum3;
  end

  // stage 4: partial products, signed high half and unsigned low half
  logic [7:0] tg4;
  logic cr4, ok4;
  logic signed [2*H-1:0] phh [3];
  logic signed [Q:0]     phl [3];
  logic signed [Q:0]     plh [3];
  logic        [2*K-1:0] pll [3];
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      tg4 <= tg3; cr4 <= cr3; ok4 <= ok3;
      for (int j = 0; j < 3; j++) begin
        phh[j] <= (2*H)'($signed(opa[j][Q-1:K]) * $signed(opb[j][Q-1:K]));
        phl[j] <= (Q+1)'($signed(opa[j][Q-1:K]) * $signed({1'b0, opb[j][K-1:0]}));
        plh[j] <= (Q+1)'($signed({1'b0, opa[j][K-1:0]}) * $signed(opb[j][Q-1:K]));
        pll[j] <= (2*K)'(opa[j][K-1:0] * opb[j][K-1:0]);
      end
    end
  end

  // stage 5: assemble the full products
  logic [7:0] tg5;
  logic cr5, ok5;
  logic signed [W-1:0] prod5 [3];
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      tg5 <= tg4; cr5 <= cr4; ok5 <= ok4;
      for (int j = 0; j < 3; j++)
        prod5[j] <= (W'(phh[j]) <<< (2 * K)) + (W'(phl[j]) <<< K) +
                    (W'(plh[j]) <<< K) + W'(pll[j]);
    end
  end

  // stage 6: 0 < num < den
  logic signed [W:0] num;
  logic signed [W+1:0] rem;
  result_t res6;
  always_comb begin
    num = (W+1)'(prod5[0]) + (W+1)'(prod5[1]);
    rem = (W+2)'(prod5[2]) - (W+2)'(num);
  end
  always_ff @(posedge clk) begin
    if (adv[6]) begin
      res6.tag_out  <= tg5;
      res6.crossed  <= cr5;
      res6.reflects <= ok5 && !num[W] && (num != 0) && !rem[W+1] && (rem != 0);
    end
  end

  assign res_out.valid    = vld[NST-1];
  assign res_out.tag_out  = res6.tag_out;
  assign res_out.crossed  = res6.crossed;
  assign res_out.reflects = res6.reflects;
endmodule

FILE: verif/tb_wall_reflection_path_test_unit.sv
// ----------------------------------------------------------------------------
// tb_wall_reflection_path_test_unit
// Streams wall segments through the unit under several source/target
// settings and checks every result beat against an exact integer predictor
// of the direct crossing and the single reflection path.
// ----------------------------------------------------------------------------
module tb_wall_reflection_path_test_unit;
  import wrpt_pkg::*;

  localparam int CB = 16;
  localparam int PHASES = 10;
  localparam int PHASE_WALLS = 85;
  localparam int LONG_HOLD = 300;

  typedef logic signed [CB-1:0] coord_t;

  // Directed plan: a row either moves the points or sends one wall
  typedef enum bit {ROW_POINTS, ROW_WALL} row_kind_t;
  typedef struct {
    row_kind_t  kind;
    logic [7:0] tag;
    coord_t     a, b, c, d;   // points: sx sy tx ty; wall: x1 y1 x2 y2
    bit         typed;        // expected flags given in the row
    bit         cross_exp, refl_exp;
  } plan_row_t;

  localparam coord_t CMIN = -32768;
  localparam coord_t CMAX = 32767;

  plan_row_t plan [20] = '{
    // right after reset S = T = origin, so nothing can cross
    '{ROW_WALL,   8'h00, -256, -256, 256, 256, 1, 0, 0},
    '{ROW_POINTS, 8'h00, 0, -512, 0, 512, 0, 0, 0},
    '{ROW_WALL,   8'h01, -256, 0, 256, 0, 1, 1, 0},     // clean cross, sides differ
    '{ROW_WALL,   8'h02, 100, 100, 100, 100, 1, 0, 0}, // zero-length wall
    '{ROW_WALL,   8'h03, 0, 0, 256, 0, 1, 0, 0},       // wall end touches S-T
    '{ROW_WALL,   8'h04, 0, -100, 0, 100, 1, 0, 0},    // collinear overlap
    '{ROW_WALL,   8'hFF, CMIN, 0, CMAX, 0, 1, 1, 0},   // widest wall
    '{ROW_WALL,   8'h80, CMAX, CMAX, CMIN, CMIN, 0, 0, 0},
    '{ROW_POINTS, 8'h00, -512, 256, 512, 256, 0, 0, 0},
    '{ROW_WALL,   8'h5A, -1024, 0, 1024, 0, 1, 0, 1},  // mirror path hits
    '{ROW_WALL,   8'h5B, 256, 0, 1024, 0, 1, 0, 0},    // mirror path misses
    '{ROW_WALL,   8'h5C, 0, 0, 1024, 0, 1, 0, 0},      // hit exactly at wall end
    '{ROW_WALL,   8'h5D, -1024, 512, 1024, 512, 0, 0, 0},
    '{ROW_WALL,   8'h5E, 0, 0, 0, 1024, 1, 1, 0},
    '{ROW_WALL,   8'h5F, -512, 0, -512, 1024, 1, 0, 0}, // source on wall line
    '{ROW_POINTS, 8'h00, CMIN, CMIN, CMAX, CMAX, 0, 0, 0},
    '{ROW_WALL,   8'hAA, CMIN, CMAX, CMAX, CMIN, 0, 0, 0},
    '{ROW_WALL,   8'h55, CMAX, CMIN, CMAX, CMAX, 1, 0, 0}, // target on wall line
    '{ROW_WALL,   8'hFE, CMIN, CMIN, CMIN, CMIN, 1, 0, 0},
    '{ROW_WALL,   8'h7F, 0, CMIN, CMAX, 0, 0, 0, 0}
  };

  logic          clk = 1'b0;
  logic          rst;
  logic          cfg_we;
  logic [1:0]    cfg_index;
  logic [CB-1:0] cfg_data;

  wrpt_wall_if #(.COORD_BITS(CB)) wall_in ();
  wrpt_res_if                     res_out ();

  wall_reflection_path_test_unit #(.COORD_BITS(CB)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wall_in   (wall_in),
    .res_out   (res_out)
  );

  always #5 clk = ~clk;

  // Shadow copy of the point registers
  coord_t pt_sx, pt_sy, pt_tx, pt_ty;

  result_t path_q [$];   // predicted results, oldest first
  int      mismatches;
  int      walls_sent, results_seen, cross_hits, refl_hits;
  bit      calm;         // no receiver stalls at the end
  bit      hold_req, hold_done;
  int      hold_cnt, stall_cnt;

  function automatic int sgn(longint v);
    if (v > 0) return 1;
    if (v < 0) return -1;
    return 0;
  endfunction

  function automatic longint xprod(longint ax, longint ay, longint bx, longint by);
    return ax * by - ay * bx;
  endfunction

  // Exact crossing and mirror-path decision for one wall
  function automatic result_t predict_path(logic [7:0] tag, coord_t wx1, coord_t wy1,
                                           coord_t wx2, coord_t wy2);
    longint sx = pt_sx, sy = pt_sy, tx = pt_tx, ty = pt_ty;
    longint x1 = wx1, y1 = wy1, x2 = wx2, y2 = wy2;
    longint dx, dy, len2, rx, ry, qx, qy, hs, ht, ps, pt;
    logic signed [127:0] w_ps, w_pt, w_hs, w_ht, w_len, num, den;
    int o1, o2, o3, o4;
    result_t r;
    r.tag_out = tag;
    o1 = sgn(xprod(tx - sx, ty - sy, x1 - sx, y1 - sy));
    o2 = sgn(xprod(tx - sx, ty - sy, x2 - sx, y2 - sy));
    o3 = sgn(xprod(x2 - x1, y2 - y1, sx - x1, sy - y1));
    o4 = sgn(xprod(x2 - x1, y2 - y1, tx - x1, ty - y1));
    r.crossed = (o1 * o2 < 0) && (o3 * o4 < 0);
    dx = x2 - x1; dy = y2 - y1;
    len2 = dx * dx + dy * dy;
    rx = sx - x1; ry = sy - y1; qx = tx - x1; qy = ty - y1;
    hs = xprod(dx, dy, rx, ry);
    ht = xprod(dx, dy, qx, qy);
    r.reflects = 1'b0;
    // needs a real wall with S and T strictly on the same side of its line
    if (len2 != 0 && hs != 0 && ht != 0 && ((hs < 0) == (ht < 0))) begin
      if (hs < 0) begin
        hs = -hs;
        ht = -ht;
      end
      ps = dx * rx + dy * ry;
      pt = dx * qx + dy * qy;
      w_ps = ps; w_pt = pt; w_hs = hs; w_ht = ht; w_len = len2;
      // hit point along the wall is num/den, must lie strictly inside (0,1)
      num = w_ps * w_ht + w_pt * w_hs;
      den = w_len * (w_hs + w_ht);
      r.reflects = (num > 0) && (den - num > 0);
    end
    return r;
  endfunction

  // Point writes, only while the pipe is empty
  task automatic set_points(coord_t sx, coord_t sy, coord_t tx, coord_t ty);
    logic [1:0] idx [4] = '{REG_SOURCE_X, REG_SOURCE_Y, REG_TARGET_X, REG_TARGET_Y};
    coord_t     val [4];
    val = '{sx, sy, tx, ty};
    wall_in.valid <= 1'b0;
    wait (path_q.size() == 0);
    repeat (8) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    pt_sx = sx; pt_sy = sy; pt_tx = tx; pt_ty = ty;
  endtask

  // One wall beat; the prediction is queued at the accepting edge
  task automatic send_wall(logic [7:0] tag, coord_t x1, coord_t y1, coord_t x2, coord_t y2);
    if (!calm && $urandom_range(0, 4) == 0) begin
      wall_in.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    wall_in.valid    <= 1'b1;
    wall_in.wall_tag <= tag;
    wall_in.wall_x1  <= x1;
    wall_in.wall_y1  <= y1;
    wall_in.wall_x2  <= x2;
    wall_in.wall_y2  <= y2;
    do @(posedge clk); while (!wall_in.ready);
    path_q.insert(path_q.size(), predict_path(tag, x1, y1, x2, y2));
    walls_sent++;
  endtask

  function automatic coord_t near(coord_t c, int span);
    int v;
    v = int'(c) + $urandom_range(0, 2 * span) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return coord_t'(v);
  endfunction

  function automatic coord_t pick_point(int mode);
    coord_t ext [3] = '{CMIN, CMAX, 0};
    case (mode)
      0:       return ext[$urandom_range(0, 2)];
      1:       return coord_t'($urandom);
      default: return coord_t'($urandom_range(0, 4096) - 2048);
    endcase
  endfunction

  // Receiver: random stall bursts, one long hold, then always ready
  always @(posedge clk) begin
    if (rst) begin
      res_out.ready <= 1'b0;
      hold_done     <= 1'b0;
      hold_cnt      <= 0;
      stall_cnt     <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done     <= 1'b1;
      hold_cnt      <= LONG_HOLD;
      res_out.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt      <= hold_cnt - 1;
      res_out.ready <= (hold_cnt == 1);
    end else if (calm) begin
      res_out.ready <= 1'b1;
    end else if (stall_cnt > 0) begin
      stall_cnt     <= stall_cnt - 1;
      res_out.ready <= (stall_cnt == 1);
    end else if ($urandom_range(0, 6) == 0) begin
      stall_cnt     <= $urandom_range(1, 10);
      res_out.ready <= 1'b0;
    end else begin
      res_out.ready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && res_out.valid && res_out.ready) begin
      results_seen++;
      if (path_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: tag %0d crossed %0d reflects %0d",
                   res_out.tag_out, res_out.crossed, res_out.reflects);
      end else begin
        want = path_q.pop_front();
        cross_hits += want.crossed;
        refl_hits  += want.reflects;
        if (res_out.tag_out !== want.tag_out || res_out.crossed !== want.crossed ||
            res_out.reflects !== want.reflects) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp tag %0d crossed %0d reflects %0d, got %0d %0d %0d",
                     want.tag_out, want.crossed, want.reflects,
                     res_out.tag_out, res_out.crossed, res_out.reflects);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    coord_t x1, y1, x2, y2, mx, my;
    result_t want;
    int mode, kind;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = REG_SOURCE_X; cfg_data = '0;
    wall_in.valid = 1'b0; wall_in.wall_tag = '0;
    wall_in.wall_x1 = '0; wall_in.wall_y1 = '0; wall_in.wall_x2 = '0; wall_in.wall_y2 = '0;
    pt_sx = '0; pt_sy = '0; pt_tx = '0; pt_ty = '0;
    mismatches = 0; walls_sent = 0; results_seen = 0; cross_hits = 0; refl_hits = 0;
    calm = 1'b0; hold_req = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed plan; typed rows must agree with the predictor too
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_POINTS) begin
        set_points(plan[i].a, plan[i].b, plan[i].c, plan[i].d);
      end else begin
        if (plan[i].typed) begin
          want = predict_path(plan[i].tag, plan[i].a, plan[i].b, plan[i].c, plan[i].d);
          if (want.crossed !== plan[i].cross_exp || want.reflects !== plan[i].refl_exp) begin
            mismatches++;
            if (mismatches <= 10)
              $display("plan row %0d: table says %0d %0d, predictor %0d %0d", i,
                       plan[i].cross_exp, plan[i].refl_exp, want.crossed, want.reflects);
          end
        end
        send_wall(plan[i].tag, plan[i].a, plan[i].b, plan[i].c, plan[i].d);
      end
    end

    // Random phases: extremes, full-range and close-in point settings
    for (int p = 0; p < PHASES; p++) begin
      mode = (p == 0 || p == 5) ? 0 : (p % 3 == 1) ? 1 : 2;
      set_points(pick_point(mode), pick_point(mode), pick_point(mode), pick_point(mode));
      if (p == 4) hold_req <= 1'b1;   // long receiver hold, sender keeps offering
      if (p == PHASES - 2) calm = 1'b1;
      mx = coord_t'((int'(pt_sx) + int'(pt_tx)) / 2);
      my = coord_t'((int'(pt_sy) + int'(pt_ty)) / 2);
      for (int n = 0; n < PHASE_WALLS; n++) begin
        kind = $urandom_range(0, 9);
        x1 = near(mx, 2048); y1 = near(my, 2048);
        x2 = near(mx, 2048); y2 = near(my, 2048);
        case (kind)
          0, 1: begin
            x1 = coord_t'($urandom); y1 = coord_t'($urandom);
            x2 = coord_t'($urandom); y2 = coord_t'($urandom);
          end
          2: begin x2 = x1; y2 = y1; end              // zero length
          3: begin x1 = pt_tx; y1 = pt_ty; end        // touches the target
          4: begin x1 = mx; y1 = my; end              // touches the S-T path
          default: ;
        endcase
        send_wall(8'($urandom), x1, y1, x2, y2);
      end
    end

    wall_in.valid <= 1'b0;
    wait (path_q.size() == 0);
    repeat (12) @(posedge clk);
    if (path_q.size() != 0) mismatches++;

    $display("%0d walls over %0d point settings, %0d results checked", walls_sent,
             PHASES + 4, results_seen);
    $display("%0d direct crossings, %0d reflection paths, %0d mismatches",
             cross_hits, refl_hits, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
